>>> hdl/ami_pkg.sv
`timescale 1ns / 1ps
// shared constants, types and operation sequencing for the affine matrix inverse
package ami_pkg;

    localparam int FRAC_BITS = 16;
    localparam int ENT_W     = 32;
    localparam int COF_W     = 2 * ENT_W;
    localparam int ACC_W     = 128;
    localparam int DIV_W     = ACC_W + 2;
    localparam int Q_W       = ENT_W + 1;
    localparam int LIN_SHIFT = 2 * FRAC_BITS;
    localparam int IN_W      = 12 * ENT_W;
    localparam int ROW_W     = 2;
    localparam int FLD_W     = ROW_W + 4 * ENT_W;
    localparam int OUT_W     = ((FLD_W + 7) / 8) * 8;
    localparam int PAD_W     = OUT_W - FLD_W;
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int STEP_W    = 6;
    localparam int STEP_LAST = 41;
    localparam int CNT_W     = $clog2(Q_W);
    localparam int DIV_LAST  = Q_W - 1;

    localparam logic [ENT_W-1:0] FX_ONE = ENT_W'(1) << FRAC_BITS;

    // multiplier x operand kinds
    localparam logic [1:0] XK_A   = 2'd0;
    localparam logic [1:0] XK_CLO = 2'd1;
    localparam logic [1:0] XK_CHI = 2'd2;

    // accumulator targets: 0..8 are the cofactors
    localparam logic [3:0] DST_DET = 4'd9;
    localparam logic [3:0] DST_T0  = 4'd10;

    localparam logic [ROW_W-1:0] ROW_LAST = 2'd2;

    typedef struct packed {
        logic                      singular;
        logic [ACC_W-1:0]          det;
        logic [8:0][COF_W-1:0]     cof;
        logic [2:0][ACC_W-1:0]     tr;
    } job_t;

    typedef struct packed {
        logic [1:0] xkind;
        logic [3:0] xidx;
        logic [3:0] yidx;
        logic [3:0] dst;
        logic       sub;
        logic       hi;
        logic       clr;
    } op_t;

    typedef struct packed {
        logic load;
        logic step;
    } lane_ctl_t;

    typedef enum logic [1:0] {F_IDLE, F_RUN, F_LAST, F_PUSH} front_state_t;
    typedef enum logic [1:0] {B_IDLE, B_LOAD, B_DIV, B_OUT} back_state_t;

    function automatic logic [1:0] nx3(input logic [1:0] v);
        return (v == 2'd2) ? 2'd0 : v + 2'd1;
    endfunction

    // flat 0..8 index to {row, col}
    function automatic logic [3:0] split3(input logic [3:0] k);
        logic [3:0] r;
        unique case (k)
            4'd0: r = {2'd0, 2'd0};
            4'd1: r = {2'd0, 2'd1};
            4'd2: r = {2'd0, 2'd2};
            4'd3: r = {2'd1, 2'd0};
            4'd4: r = {2'd1, 2'd1};
            4'd5: r = {2'd1, 2'd2};
            4'd6: r = {2'd2, 2'd0};
            4'd7: r = {2'd2, 2'd1};
            4'd8: r = {2'd2, 2'd2};
            default: r = '0;
        endcase
        return r;
    endfunction

    // one multiply-accumulate per step: cofactors, then determinant, then translation
    function automatic op_t op_of(input logic [STEP_W-1:0] step);
        op_t o;
        logic [3:0] ij;
        logic [1:0] i;
        logic [1:0] j;
        logic [1:0] i1;
        logic [1:0] i2;
        logic [1:0] j1;
        logic [1:0] j2;
        logic [2:0] m3;
        logic [4:0] m5;
        o  = '0;
        m3 = 3'(step - STEP_W'(18));
        m5 = 5'(step - STEP_W'(24));
        if (step < STEP_W'(18)) begin
            ij = split3(step[4:1]);
            i  = ij[3:2];
            j  = ij[1:0];
            i1 = nx3(i);
            i2 = nx3(i1);
            j1 = nx3(j);
            j2 = nx3(j1);
            o.xkind = XK_A;
            o.xidx  = step[0] ? {j1, i2} : {j1, i1};
            o.yidx  = step[0] ? {j2, i1} : {j2, i2};
            o.dst   = step[4:1];
            o.sub   = step[0];
            o.hi    = 1'b0;
            o.clr   = !step[0];
        end else if (step < STEP_W'(24)) begin
            j = m3[2:1];
            o.xkind = m3[0] ? XK_CHI : XK_CLO;
            o.xidx  = {2'd0, j} * 4'd3;
            o.yidx  = {2'd0, j};
            o.dst   = DST_DET;
            o.sub   = 1'b0;
            o.hi    = m3[0];
            o.clr   = (m3 == 3'd0);
        end else begin
            ij = split3(m5[4:1]);
            i  = ij[3:2];
            j  = ij[1:0];
            o.xkind = m5[0] ? XK_CHI : XK_CLO;
            o.xidx  = m5[4:1];
            o.yidx  = {j, 2'd3};
            o.dst   = DST_T0 + {2'd0, i};
            o.sub   = 1'b1;
            o.hi    = m5[0];
            o.clr   = (j == 2'd0) && !m5[0];
        end
        return o;
    endfunction

endpackage

>>> hdl/ami_front.sv
`timescale 1ns / 1ps
// front end: input buffer and multiply-accumulate sequencer for cofactors, det and translation
module ami_front (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [ami_pkg::IN_W-1:0]  in_data,
    output logic                      push,
    input  logic                      q_full,
    output ami_pkg::job_t             job
);
    import ami_pkg::*;

    logic [IN_W-1:0]              buf_reg;
    logic                         buf_vld_reg, buf_vld_next;
    logic [2:0][3:0][ENT_W-1:0]   a_reg;
    logic [8:0][COF_W-1:0]        cof_reg;
    logic [ACC_W-1:0]             det_reg;
    logic [2:0][ACC_W-1:0]        tr_reg;
    front_state_t                 state_reg, state_next;
    logic [STEP_W-1:0]            step_reg, step_next;
    op_t                          op, mop_reg;
    logic                         mvld_reg, mvld_next;
    logic                         load_a;
    logic [ENT_W-1:0]             xa, ya;
    logic [COF_W-1:0]             xc;
    logic signed [ENT_W:0]        x_op, y_op;
    logic signed [2*ENT_W+1:0]    prod, prod_reg;
    logic signed [ACC_W-1:0]      pext, cur, base, acc_res;

    // operand select and multiply
    always_comb begin
        op = op_of(step_reg);
        xa = a_reg[op.xidx[3:2]][op.xidx[1:0]];
        ya = a_reg[op.yidx[3:2]][op.yidx[1:0]];
        xc = cof_reg[op.xidx];
        y_op = {ya[ENT_W-1], ya};
        unique case (op.xkind)
            XK_A:    x_op = {xa[ENT_W-1], xa};
            XK_CLO:  x_op = {1'b0, xc[ENT_W-1:0]};
            XK_CHI:  x_op = {xc[COF_W-1], xc[COF_W-1:ENT_W]};
            default: x_op = '0;
        endcase
        prod = x_op * y_op;
    end

    // accumulate the registered product
    always_comb begin
        pext = ACC_W'(prod_reg);
        if (mop_reg.hi) begin
            pext = pext <<< ENT_W;
        end
        if (mop_reg.dst < DST_DET) begin
            cur = ACC_W'(signed'(cof_reg[mop_reg.dst]));
        end else if (mop_reg.dst == DST_DET) begin
            cur = det_reg;
        end else begin
            cur = tr_reg[2'(mop_reg.dst - DST_T0)];
        end
        base    = mop_reg.clr ? '0 : cur;
        acc_res = mop_reg.sub ? base - pext : base + pext;
    end

    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        buf_vld_next = buf_vld_reg;
        mvld_next    = 1'b0;
        load_a       = 1'b0;
        push         = 1'b0;
        in_ready     = !buf_vld_reg;
        if (in_valid && in_ready) begin
            buf_vld_next = 1'b1;
        end
        unique case (state_reg)
            F_IDLE: begin
                if (buf_vld_reg) begin
                    load_a       = 1'b1;
                    buf_vld_next = 1'b0;
                    step_next    = '0;
                    state_next   = F_RUN;
                end
            end
            F_RUN: begin
                mvld_next = 1'b1;
                if (step_reg == STEP_W'(STEP_LAST)) begin
                    state_next = F_LAST;
                end else begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            F_LAST: begin
                state_next = F_PUSH;
            end
            F_PUSH: begin
                if (!q_full) begin
                    push       = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= F_IDLE;
            step_reg    <= '0;
            buf_vld_reg <= 1'b0;
            mvld_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            buf_vld_reg <= buf_vld_next;
            mvld_reg    <= mvld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            buf_reg <= in_data;
        end
        if (load_a) begin
            a_reg <= buf_reg;
        end
        mop_reg  <= op;
        prod_reg <= prod;
        if (mvld_reg) begin
            if (mop_reg.dst < DST_DET) begin
                cof_reg[mop_reg.dst] <= acc_res[COF_W-1:0];
            end else if (mop_reg.dst == DST_DET) begin
                det_reg <= acc_res;
            end else begin
                tr_reg[2'(mop_reg.dst - DST_T0)] <= acc_res;
            end
        end
    end

    assign job.singular = (det_reg == '0);
    assign job.det      = det_reg;
    assign job.cof      = cof_reg;
    assign job.tr       = tr_reg;

endmodule

>>> hdl/ami_queue.sv
`timescale 1ns / 1ps
// short job queue between the front end and the divider back end
module ami_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  ami_pkg::job_t wr_job,
    output logic          full,
    input  logic          pop,
    output ami_pkg::job_t rd_job,
    output logic          empty
);
    import ami_pkg::*;

    job_t               mem_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]    cnt_reg;

    assign full   = (cnt_reg == (QPTR_W+1)'(QDEPTH));
    assign empty  = (cnt_reg == '0);
    assign rd_job = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + (QPTR_W+1)'(1);
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - (QPTR_W+1)'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

>>> hdl/ami_div_lane.sv
`timescale 1ns / 1ps
// one bit-serial restoring divider lane with truncation and saturation to 32 bits
module ami_div_lane (
    input  logic                       aclk,
    input  ami_pkg::lane_ctl_t         ctl,
    input  logic [ami_pkg::ACC_W-1:0]  num,
    input  logic [ami_pkg::ACC_W-1:0]  den,
    output logic [ami_pkg::ENT_W-1:0]  quo
);
    import ami_pkg::*;

    logic [DIV_W-1:0] rem_reg, dsh_reg;
    logic [Q_W-1:0]   q_reg;
    logic             neg_reg;
    logic [ACC_W-1:0] num_abs, den_abs;
    logic             ge;
    logic [ENT_W-1:0] lim, mag;

    always_comb begin
        num_abs = num[ACC_W-1] ? (~num + ACC_W'(1)) : num;
        den_abs = den[ACC_W-1] ? (~den + ACC_W'(1)) : den;
        ge      = (rem_reg >= dsh_reg);
        lim     = neg_reg ? {1'b1, {(ENT_W-1){1'b0}}} : {1'b0, {(ENT_W-1){1'b1}}};
        mag     = (q_reg[Q_W-1] || (q_reg[ENT_W-1:0] > lim)) ? lim : q_reg[ENT_W-1:0];
        quo     = neg_reg ? (~mag + ENT_W'(1)) : mag;
    end

    // first step tests the bit above the result range, which flags saturation
    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            rem_reg <= DIV_W'(num_abs);
            dsh_reg <= DIV_W'(den_abs) << ENT_W;
            q_reg   <= '0;
            neg_reg <= num[ACC_W-1] ^ den[ACC_W-1];
        end else if (ctl.step) begin
            if (ge) begin
                rem_reg <= rem_reg - dsh_reg;
            end
            q_reg   <= {q_reg[Q_W-2:0], ge};
            dsh_reg <= dsh_reg >> 1;
        end
    end

endmodule

>>> hdl/ami_back.sv
`timescale 1ns / 1ps
// back end: per-row division over four lanes and the output register
module ami_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       empty,
    input  ami_pkg::job_t              job,
    output logic                       pop,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [ami_pkg::OUT_W-1:0]  m_tdata,
    output logic                       m_tlast,
    output logic                       m_tuser
);
    import ami_pkg::*;

    back_state_t              state_reg, state_next;
    logic [ROW_W-1:0]         row_reg, row_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    lane_ctl_t                ctl;
    logic [3:0][ACC_W-1:0]    num;
    logic [3:0][ENT_W-1:0]    quo;
    logic [3:0]               cof_base;
    logic                     out_wr;
    logic                     ovld_reg, ovld_next;
    logic [ROW_W-1:0]         orow_reg;
    logic [3:0][ENT_W-1:0]    ocol_reg;
    logic                     osing_reg, olast_reg;

    // numerators of the current row: cofactors scaled by 2F, translation by F
    always_comb begin
        cof_base = {2'd0, row_reg} * 4'd3;
        for (int j = 0; j < 3; j++) begin
            num[j] = ACC_W'(signed'(job.cof[cof_base + 4'(j)])) <<< LIN_SHIFT;
        end
        num[3] = job.tr[row_reg] << FRAC_BITS;
    end

    for (genvar g = 0; g < 4; g++) begin : g_lane
        ami_div_lane u_lane (
            .aclk (aclk),
            .ctl  (ctl),
            .num  (num[g]),
            .den  (job.det),
            .quo  (quo[g])
        );
    end

    always_comb begin
        state_next = state_reg;
        row_next   = row_reg;
        cnt_next   = cnt_reg;
        ctl        = '0;
        pop        = 1'b0;
        out_wr     = 1'b0;
        unique case (state_reg)
            B_IDLE: begin
                if (!empty) begin
                    row_next   = '0;
                    state_next = B_LOAD;
                end
            end
            B_LOAD: begin
                if (job.singular) begin
                    state_next = B_OUT;
                end else begin
                    ctl.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = B_DIV;
                end
            end
            B_DIV: begin
                ctl.step = 1'b1;
                if (cnt_reg == CNT_W'(DIV_LAST)) begin
                    state_next = B_OUT;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            B_OUT: begin
                if (!ovld_reg || m_tready) begin
                    out_wr = 1'b1;
                    if (row_reg == ROW_LAST) begin
                        pop        = 1'b1;
                        state_next = B_IDLE;
                    end else begin
                        row_next   = row_reg + ROW_W'(1);
                        state_next = B_LOAD;
                    end
                end
            end
            default: state_next = B_IDLE;
        endcase
        if (out_wr) begin
            ovld_next = 1'b1;
        end else if (m_tready) begin
            ovld_next = 1'b0;
        end else begin
            ovld_next = ovld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
            row_reg   <= '0;
            cnt_reg   <= '0;
            ovld_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            row_reg   <= row_next;
            cnt_reg   <= cnt_next;
            ovld_reg  <= ovld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_wr) begin
            orow_reg  <= row_reg;
            osing_reg <= job.singular;
            olast_reg <= (row_reg == ROW_LAST);
            for (int j = 0; j < 3; j++) begin
                if (job.singular) begin
                    ocol_reg[j] <= (row_reg == ROW_W'(j)) ? FX_ONE : '0;
                end else begin
                    ocol_reg[j] <= quo[j];
                end
            end
            ocol_reg[3] <= job.singular ? '0 : quo[3];
        end
    end

    assign m_tvalid = ovld_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, ocol_reg, orow_reg};
    assign m_tlast  = olast_reg;
    assign m_tuser  = osing_reg;

endmodule

>>> hdl/affine_matrix_inverse.sv
`timescale 1ns / 1ps
// top level of the 3x4 affine matrix inverse in signed Q16.16
//
// usage:
//   s_ channel: one request is a whole 3x4 affine matrix, twelve Q16.16 entries
//   m_ channel: three results per request, one per row of the inverse, row 0 first;
//     tlast marks row 2, tuser flags a singular matrix (identity rows are returned)
// the front end has one 33x33 multiplier stepping through 42 multiply-accumulates
//   for cofactors, determinant and translation; the back end divides each row in
//   four 33-step bit-serial dividers, one per column
// the back end takes the next job only after the last row of the current one; a
//   singular matrix skips the division
// the input buffer takes a new request while the front end still works, and a
//   two-entry job queue lets the front end run ahead of the back end
// a stalled receiver holds the output register; the back end waits in its output
//   step and the queue and front end fill behind it
// reset (aresetn low, synchronous) empties the buffer, queue and output register
module affine_matrix_inverse (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // a00, a01, a02, a03, a10, a11, a12, a13, a20, a21, a22, a23 (32 bits each)
    input  logic [ami_pkg::IN_W-1:0]   s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // row_index (2), col0, col1, col2, col3 (32 each), zero pad
    output logic [ami_pkg::OUT_W-1:0]  m_tdata,
    output logic                       m_tlast,
    // singular
    output logic                       m_tuser
);
    import ami_pkg::*;

    job_t front_job, head_job;
    logic push, q_full, pop, q_empty;

    // front: buffer, multiplier and accumulators
    ami_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_data  (s_tdata),
        .push     (push),
        .q_full   (q_full),
        .job      (front_job)
    );

    // decouples the two halves
    ami_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wr_job  (front_job),
        .full    (q_full),
        .pop     (pop),
        .rd_job  (head_job),
        .empty   (q_empty)
    );

    // back: division lanes and result register
    ami_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .empty    (q_empty),
        .job      (head_job),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

`ifndef ASSERT_OFF
    // front end never pushes into a full queue
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && q_full))
        else $error("job queue overflow");

    // tlast marks exactly the last row
    a_last_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tdata[ROW_W-1:0] == ROW_LAST)))
        else $error("tlast does not match row index");

    // singular rows carry no translation
    a_sing_trans: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[FLD_W-1:FLD_W-ENT_W] == '0))
        else $error("singular row with nonzero translation");
`endif

endmodule
